>>> hw/rtl/fjs_pkg.sv
// Shared types and constants for the FIFO job scheduler.
// Used by fjs_ctrl, fjs_outreg and the top level; depends on nothing.
`default_nettype none

package fjs_pkg;

    localparam int FIELD_W     = 16;
    localparam int CNT_W       = 3;
    localparam int QMAX_W      = 3;
    localparam int MAX_RESULTS = 5;

    localparam logic [QMAX_W-1:0] QMAX_RESET = 3'd3;

    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    // One job as stored in the wait queue and in the server slot
    typedef struct packed {
        logic [FIELD_W-1:0] timeout;
        logic [FIELD_W-1:0] duration;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] oid;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] oid;
        logic [FIELD_W-1:0] stamp;
        logic [FIELD_W-1:0] delay;
    } rec_t;

    typedef struct packed {
        logic valid;
        logic last;
        rec_t rec;
    } push_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_READ,
        ST_CHECK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        state_t           state;
        logic             busy;
        logic             pend_valid;
        logic [CNT_W-1:0] count;
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/fifo_job_scheduler_with_timeout.sv
// Single-server job scheduler with a bounded wait queue and job timeouts.
// Input channel (in_valid / in_stall): req_type selects an arrival (with
// job_oid, job_duration, job_timeout) or a clock tick. Output channel
// (out_valid / out_stall): one record word per finished or aborted job;
// last_record marks the final word caused by one input word.
// Configuration: cfg_we writes cfg_wdata into queue_max (reset value 3).
// Sequence: an arrival is handled in ST_IDLE, a rejected one then in ST_FLUSH.
// A tick passes ST_TICK and ST_READ, then for each dequeued entry a read of
// the wait-queue RAM (registered read) in ST_READ and a check in ST_CHECK;
// it ends in ST_FLUSH. One record is held back internally so the last one
// can be marked; a record passes from that held-back register into the
// output register.
// While the output register is full and stalled, the sequencer holds
// whenever it has a further record to hand on; in_stall stays high.
// Reset clears clock, server, queue pointers and the output register;
// the queue RAM needs no clearing as entries are written before read.
// Depends on fjs_pkg, fjs_ctrl, fjs_ram and fjs_outreg.
`default_nettype none

module fifo_job_scheduler_with_timeout #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [fjs_pkg::FIELD_W-1:0] job_oid,
    input  logic [fjs_pkg::FIELD_W-1:0] job_duration,
    input  logic [fjs_pkg::FIELD_W-1:0] job_timeout,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        record_kind,
    output logic [fjs_pkg::FIELD_W-1:0] record_oid,
    output logic [fjs_pkg::FIELD_W-1:0] record_time,
    output logic [fjs_pkg::FIELD_W-1:0] record_delay,
    output logic                        last_record,
    input  logic                        cfg_we,
    input  logic [fjs_pkg::QMAX_W-1:0]  cfg_wdata
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LIMIT = (QUEUE_DEPTH < fjs_pkg::MAX_RESULTS - 1) ?
                           QUEUE_DEPTH : fjs_pkg::MAX_RESULTS - 1;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    fjs_pkg::job_t     ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    fjs_pkg::job_t     ram_rdata;
    logic              out_ready;
    fjs_pkg::push_t    push;
    fjs_pkg::status_t  status;

    fjs_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .job_oid      (job_oid),
        .job_duration (job_duration),
        .job_timeout  (job_timeout),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .out_ready    (out_ready),
        .push         (push),
        .status       (status)
    );

    fjs_ram #(
        .WIDTH (fjs_pkg::JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fjs_outreg u_outreg (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .ready        (out_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_kind  (record_kind),
        .record_oid   (record_oid),
        .record_time  (record_time),
        .record_delay (record_delay),
        .last_record  (last_record)
    );

    // Queue never holds more jobs than the hard limit
    assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= fjs_pkg::CNT_W'(LIMIT))
        else $error("wait queue count above limit");

    // Back in idle, nothing is held back and no job waits on an idle server
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.state == fjs_pkg::ST_IDLE) |-> (!status.pend_valid &&
            (status.busy || (status.count == '0))))
        else $error("idle with pending record or undrained queue");

    // An accepted tick always starts the drain sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (req_type == fjs_pkg::REQ_TICK)) |=>
            (status.state == fjs_pkg::ST_TICK))
        else $error("tick not followed by server check");

    // A word pushed into the output register never overwrites a waiting one
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> out_ready)
        else $error("record pushed while output register blocked");

endmodule

`default_nettype wire

>>> hw/rtl/fjs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; holds the wait queue of the job scheduler.
`default_nettype none

module fjs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fjs_outreg.sv
// Output register of the job scheduler: holds one record word until taken.
// Depends on fjs_pkg for the record types.
`default_nettype none

module fjs_outreg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fjs_pkg::push_t              push,
    output logic                        ready,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        record_kind,
    output logic [fjs_pkg::FIELD_W-1:0] record_oid,
    output logic [fjs_pkg::FIELD_W-1:0] record_time,
    output logic [fjs_pkg::FIELD_W-1:0] record_delay,
    output logic                        last_record
);

    logic           valid_reg;
    logic           valid_next;
    fjs_pkg::rec_t  rec_reg;
    logic           last_reg;

    assign ready      = !valid_reg || !out_stall;
    assign valid_next = push.valid || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: load only on a push, which the controller issues when ready
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            rec_reg  <= push.rec;
            last_reg <= push.last;
        end
    end

    assign out_valid    = valid_reg;
    assign record_kind  = rec_reg.kind;
    assign record_oid   = rec_reg.oid;
    assign record_time  = rec_reg.stamp;
    assign record_delay = rec_reg.delay;
    assign last_record  = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fjs_ctrl.sv
// Scheduler controller: clock, server slot, queue pointers and the sequencer
// that drains the wait queue from the RAM. Depends on fjs_pkg.
`default_nettype none

module fjs_ctrl #(
    parameter int QUEUE_DEPTH = 4,
    localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic [fjs_pkg::FIELD_W-1:0]  job_oid,
    input  logic [fjs_pkg::FIELD_W-1:0]  job_duration,
    input  logic [fjs_pkg::FIELD_W-1:0]  job_timeout,
    input  logic                         cfg_we,
    input  logic [fjs_pkg::QMAX_W-1:0]   cfg_wdata,
    output logic                         ram_we,
    output logic [IDX_W-1:0]             ram_waddr,
    output fjs_pkg::job_t                ram_wdata,
    output logic                         ram_re,
    output logic [IDX_W-1:0]             ram_raddr,
    input  fjs_pkg::job_t                ram_rdata,
    input  logic                         out_ready,
    output fjs_pkg::push_t               push,
    output fjs_pkg::status_t             status
);

    localparam int CNT_W = fjs_pkg::CNT_W;
    localparam int FW    = fjs_pkg::FIELD_W;
    localparam int SUM_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam int LIMIT = (QUEUE_DEPTH < fjs_pkg::MAX_RESULTS - 1) ?
                           QUEUE_DEPTH : fjs_pkg::MAX_RESULTS - 1;
    localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(LIMIT);

    fjs_pkg::state_t             state_reg, state_next;
    logic [fjs_pkg::QMAX_W-1:0]  qmax_reg, qmax_next;
    logic [FW-1:0]               clock_reg, clock_next;
    logic                        busy_reg, busy_next;
    fjs_pkg::job_t               run_job_reg, run_job_next;
    logic [FW-1:0]               run_start_reg, run_start_next;
    logic [IDX_W-1:0]            head_reg, head_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        pend_valid_reg, pend_valid_next;
    fjs_pkg::rec_t               pend_reg, pend_next;

    logic                        accept;
    logic [CNT_W-1:0]            cap;
    logic [SUM_W-1:0]            tail_sum;
    logic [IDX_W-1:0]            tail;
    logic [IDX_W-1:0]            head_inc;
    logic [FW-1:0]               clock_inc;
    fjs_pkg::job_t               arrive_job;
    logic                        done_hit;
    logic                        run_expired;
    logic                        head_expired;
    logic                        emit_ok;

    assign accept   = in_valid && (state_reg == fjs_pkg::ST_IDLE);
    assign in_stall = (state_reg != fjs_pkg::ST_IDLE);

    assign cap = (qmax_reg > CAP_LIMIT) ? CAP_LIMIT : qmax_reg;

    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
    end

    assign tail      = tail_sum[IDX_W-1:0];
    assign head_inc  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign clock_inc = (clock_reg != '1) ? clock_reg + FW'(1) : clock_reg;

    assign arrive_job = '{timeout: job_timeout, duration: job_duration,
                          arrival: clock_reg, oid: job_oid};

    // Completion sum kept at 17 bits so a wrapped finish time never matches
    assign done_hit     = ({1'b0, run_start_reg} + {1'b0, run_job_reg.duration})
                          == {1'b0, clock_reg};
    assign run_expired  = (run_job_reg.timeout <= clock_reg);
    assign head_expired = (ram_rdata.timeout <= clock_reg);
    assign emit_ok      = !pend_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fjs_pkg::ST_IDLE;
            qmax_reg       <= fjs_pkg::QMAX_RESET;
            clock_reg      <= '0;
            busy_reg       <= 1'b0;
            run_job_reg    <= '0;
            run_start_reg  <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            qmax_reg       <= qmax_next;
            clock_reg      <= clock_next;
            busy_reg       <= busy_next;
            run_job_reg    <= run_job_next;
            run_start_reg  <= run_start_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fjs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == fjs_pkg::REQ_TICK)
                    begin
                        state_next = fjs_pkg::ST_TICK;
                    end
                    else if (busy_reg && (count_reg >= cap))
                    begin
                        state_next = fjs_pkg::ST_FLUSH;
                    end
                end
            end
            fjs_pkg::ST_TICK:
            begin
                state_next = fjs_pkg::ST_READ;
            end
            fjs_pkg::ST_READ:
            begin
                if (!busy_reg && (count_reg != '0))
                begin
                    state_next = fjs_pkg::ST_CHECK;
                end
                else
                begin
                    state_next = fjs_pkg::ST_FLUSH;
                end
            end
            fjs_pkg::ST_CHECK:
            begin
                if (!head_expired)
                begin
                    state_next = fjs_pkg::ST_FLUSH;
                end
                else if (emit_ok)
                begin
                    state_next = fjs_pkg::ST_READ;
                end
            end
            fjs_pkg::ST_FLUSH:
            begin
                if (emit_ok)
                begin
                    state_next = fjs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fjs_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        qmax_next       = cfg_we ? cfg_wdata : qmax_reg;
        clock_next      = clock_reg;
        busy_next       = busy_reg;
        run_job_next    = run_job_reg;
        run_start_next  = run_start_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail;
        ram_wdata       = arrive_job;
        ram_re          = 1'b0;
        ram_raddr       = head_reg;
        push.valid      = 1'b0;
        push.last       = 1'b0;
        push.rec        = pend_reg;

        case (state_reg)
            fjs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == fjs_pkg::REQ_TICK)
                    begin
                        clock_next = clock_inc;
                    end
                    else if (!busy_reg)
                    begin
                        run_job_next   = arrive_job;
                        run_start_next = clock_reg;
                        busy_next      = 1'b1;
                    end
                    else if (count_reg < cap)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // queue full: reject at once
                        pend_valid_next = 1'b1;
                        pend_next       = '{kind: fjs_pkg::KIND_ABORT, oid: job_oid,
                                            stamp: clock_reg, delay: '0};
                    end
                end
            end
            fjs_pkg::ST_TICK:
            begin
                if (busy_reg)
                begin
                    if (done_hit)
                    begin
                        busy_next       = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_next       = '{kind: fjs_pkg::KIND_DONE, oid: run_job_reg.oid,
                                            stamp: clock_reg,
                                            delay: run_start_reg - run_job_reg.arrival};
                    end
                    else if (run_expired)
                    begin
                        busy_next       = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_next       = '{kind: fjs_pkg::KIND_ABORT, oid: run_job_reg.oid,
                                            stamp: clock_reg,
                                            delay: clock_reg - run_job_reg.arrival};
                    end
                end
            end
            fjs_pkg::ST_READ:
            begin
                if (!busy_reg && (count_reg != '0))
                begin
                    ram_re = 1'b1;
                end
            end
            fjs_pkg::ST_CHECK:
            begin
                if (!head_expired)
                begin
                    run_job_next   = ram_rdata;
                    run_start_next = clock_reg;
                    busy_next      = 1'b1;
                    head_next      = head_inc;
                    count_next     = count_reg - CNT_W'(1);
                end
                else if (emit_ok)
                begin
                    // Hand the older record on; it cannot be the last one
                    push.valid      = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_next       = '{kind: fjs_pkg::KIND_ABORT, oid: ram_rdata.oid,
                                        stamp: clock_reg,
                                        delay: clock_reg - ram_rdata.arrival};
                    head_next       = head_inc;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            fjs_pkg::ST_FLUSH:
            begin
                if (pend_valid_reg && out_ready)
                begin
                    push.valid      = 1'b1;
                    push.last       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    assign status = '{state: state_reg, busy: busy_reg,
                      pend_valid: pend_valid_reg, count: count_reg};

endmodule

`default_nettype wire

>>> dv/fjs_sched_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the FIFO job scheduler. It follows the input, output and configuration
// ports, predicts every record word and compares the record words in order.
// Depends on fjs_pkg only.
module fjs_sched_checker
    import fjs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               req_type,
    input  logic [FIELD_W-1:0] job_oid,
    input  logic [FIELD_W-1:0] job_duration,
    input  logic [FIELD_W-1:0] job_timeout,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               record_kind,
    input  logic [FIELD_W-1:0] record_oid,
    input  logic [FIELD_W-1:0] record_time,
    input  logic [FIELD_W-1:0] record_delay,
    input  logic               last_record,
    input  logic               cfg_we,
    input  logic [QMAX_W-1:0]  cfg_wdata,
    output int                 mismatches,
    output int                 awaiting,
    output int                 words_in,
    output int                 records_out
);

    typedef struct packed {
        logic last;
        rec_t rec;
    } record_word_t;

    // A tick must never produce more records than the block can emit.
    localparam int QUEUE_CAP =
        (QUEUE_DEPTH < MAX_RESULTS - 1) ? QUEUE_DEPTH : MAX_RESULTS - 1;

    logic [QMAX_W-1:0]  qmax;
    logic [FIELD_W-1:0] sched_clock;
    logic               srv_busy;
    job_t               srv_job;
    logic [FIELD_W-1:0] srv_start;
    job_t               wait_jobs [QUEUE_DEPTH];
    int                 wait_head;
    int                 wait_count;
    record_word_t       due_records [$];

    function automatic record_word_t make_record(input logic kind,
                                                 input logic [FIELD_W-1:0] oid,
                                                 input logic [FIELD_W-1:0] stamp,
                                                 input logic [FIELD_W-1:0] delay);
        record_word_t r;
        r.last      = 1'b0;
        r.rec.kind  = kind;
        r.rec.oid   = oid;
        r.rec.stamp = stamp;
        r.rec.delay = delay;
        return r;
    endfunction

    task automatic schedule_step(input logic               kind,
                                 input logic [FIELD_W-1:0] oid,
                                 input logic [FIELD_W-1:0] dur,
                                 input logic [FIELD_W-1:0] tmo);
        record_word_t batch [$];
        job_t         job;
        int           cap;
        cap = (int'(qmax) < QUEUE_CAP) ? int'(qmax) : QUEUE_CAP;
        if (kind == REQ_ARRIVE) begin
            job.oid      = oid;
            job.arrival  = sched_clock;
            job.duration = dur;
            job.timeout  = tmo;
            if (!srv_busy) begin
                srv_job   = job;
                srv_start = sched_clock;
                srv_busy  = 1'b1;
            end
            else if (wait_count < cap) begin
                wait_jobs[(wait_head + wait_count) % QUEUE_DEPTH] = job;
                wait_count++;
            end
            else begin
                batch.push_back(make_record(KIND_ABORT, oid, sched_clock, '0));
            end
        end
        else begin
            if (sched_clock != '1)
                sched_clock++;
            if (srv_busy) begin
                // compare at 17 bits: a sum past the clock range never completes
                if ({1'b0, srv_start} + {1'b0, srv_job.duration} == {1'b0, sched_clock}) begin
                    batch.push_back(make_record(KIND_DONE, srv_job.oid, sched_clock,
                                                srv_start - srv_job.arrival));
                    srv_busy = 1'b0;
                end
                else if (srv_job.timeout <= sched_clock) begin
                    batch.push_back(make_record(KIND_ABORT, srv_job.oid, sched_clock,
                                                sched_clock - srv_job.arrival));
                    srv_busy = 1'b0;
                end
            end
            // Start waiting jobs in order and drop at once any that have already expired.
            while (!srv_busy && wait_count > 0) begin
                job        = wait_jobs[wait_head];
                wait_head  = (wait_head + 1) % QUEUE_DEPTH;
                wait_count--;
                srv_job    = job;
                srv_start  = sched_clock;
                srv_busy   = 1'b1;
                if (job.timeout <= sched_clock) begin
                    batch.push_back(make_record(KIND_ABORT, job.oid, sched_clock,
                                                sched_clock - job.arrival));
                    srv_busy = 1'b0;
                end
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            due_records.push_back(batch[i]);
    endtask

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("record %0d: %s expected %h, got %h", records_out, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        record_word_t want;
        if (!rst_n) begin
            qmax        = QMAX_RESET;
            sched_clock = '0;
            srv_busy    = 1'b0;
            srv_job     = '0;
            srv_start   = '0;
            wait_head   = 0;
            wait_count  = 0;
            due_records.delete();
            mismatches  = 0;
            awaiting    = 0;
            words_in    = 0;
            records_out = 0;
        end
        else begin
            if (cfg_we)
                qmax = cfg_wdata;
            if (in_valid && !in_stall) begin
                schedule_step(req_type, job_oid, job_duration, job_timeout);
                words_in++;
            end
            if (out_valid && !out_stall) begin
                if (due_records.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("record %0d: unexpected word, oid %h time %h",
                                 records_out, record_oid, record_time);
                end
                else begin
                    want = due_records.pop_front();
                    check_field("kind", FIELD_W'(want.rec.kind), FIELD_W'(record_kind));
                    check_field("oid", want.rec.oid, record_oid);
                    check_field("time", want.rec.stamp, record_time);
                    check_field("delay", want.rec.delay, record_delay);
                    check_field("last", FIELD_W'(want.last), FIELD_W'(last_record));
                end
                records_out++;
            end
            awaiting = due_records.size();
        end
    end

endmodule

>>> dv/fifo_job_scheduler_with_timeout_tb.sv
`timescale 1ns / 1ps
// Top of the FIFO job scheduler testbench. It generates the clock and reset, drives the job and
// tick words, writes the queue limit and reports the verdict.
// Depends on fjs_pkg, the scheduler RTL and fjs_sched_checker.
module fifo_job_scheduler_with_timeout_tb;
    import fjs_pkg::*;

    localparam int WORDS_PER_PHASE = 30;
    localparam int SETTLE_CYCLES   = 24;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               req_type     = REQ_ARRIVE;
    logic [FIELD_W-1:0] job_oid      = '0;
    logic [FIELD_W-1:0] job_duration = '0;
    logic [FIELD_W-1:0] job_timeout  = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic               record_kind;
    logic [FIELD_W-1:0] record_oid;
    logic [FIELD_W-1:0] record_time;
    logic [FIELD_W-1:0] record_delay;
    logic               last_record;
    logic               cfg_we       = 1'b0;
    logic [QMAX_W-1:0]  cfg_wdata    = '0;

    bit calm        = 1'b0;
    int clock_guess = 0;
    int stall_left  = 0;
    int cfg_writes  = 0;
    int mismatches;
    int awaiting;
    int words_in;
    int records_out;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    fifo_job_scheduler_with_timeout #(
        .QUEUE_DEPTH(4)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .job_oid      (job_oid),
        .job_duration (job_duration),
        .job_timeout  (job_timeout),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_kind  (record_kind),
        .record_oid   (record_oid),
        .record_time  (record_time),
        .record_delay (record_delay),
        .last_record  (last_record),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    fjs_sched_checker #(
        .QUEUE_DEPTH(4)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .job_oid      (job_oid),
        .job_duration (job_duration),
        .job_timeout  (job_timeout),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_kind  (record_kind),
        .record_oid   (record_oid),
        .record_time  (record_time),
        .record_delay (record_delay),
        .last_record  (last_record),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .awaiting     (awaiting),
        .words_in     (words_in),
        .records_out  (records_out)
    );

    // Receiver: after each accepted record, hold off for a random number of cycles.
    always @(posedge clk or negedge rst_n) begin : sink
        int draw;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall) begin
            draw = calm ? 0 : $urandom_range(0, 12);
            stall_left <= draw;
            out_stall  <= (draw != 0);
        end
        else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end
        else begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
    end

    task automatic send_word(input logic               kind,
                             input logic [FIELD_W-1:0] oid,
                             input logic [FIELD_W-1:0] dur,
                             input logic [FIELD_W-1:0] tmo);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        job_oid      <= oid;
        job_duration <= dur;
        job_timeout  <= tmo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (kind == REQ_TICK && clock_guess < 65535)
            clock_guess++;
    endtask

    task automatic send_random;
        logic [FIELD_W-1:0] dur;
        logic [FIELD_W-1:0] tmo;
        int                 t;
        if ($urandom_range(0, 99) < 45) begin
            send_word(REQ_TICK, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
        end
        else begin
            if ($urandom_range(0, 9) == 0) begin
                dur = FIELD_W'($urandom);
                tmo = FIELD_W'($urandom);
            end
            else begin
                // Keep most durations short so that jobs complete during the run.
                if ($urandom_range(0, 3) == 0)
                    dur = FIELD_W'($urandom);
                else
                    dur = FIELD_W'($urandom_range(0, 6));
                case ($urandom_range(0, 4))
                    0: tmo = FIELD_W'($urandom_range(0, clock_guess));
                    1: tmo = '1;
                    default:
                    begin
                        t   = clock_guess + $urandom_range(0, 12);
                        tmo = (t > 65535) ? '1 : FIELD_W'(t);
                    end
                endcase
            end
            send_word(REQ_ARRIVE, FIELD_W'($urandom), dur, tmo);
        end
    endtask

    // Hold the sender until every record due has arrived, then let the block go quiet.
    task automatic settle;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_qmax(input logic [QMAX_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    initial begin : stimulus
        logic [QMAX_W-1:0] limits [6];
        int                fails;
        limits = '{3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd4};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners with the reset queue limit of three.
        send_word(REQ_ARRIVE, 16'h0000, 16'd2, 16'hFFFF);
        send_word(REQ_ARRIVE, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_word(REQ_ARRIVE, 16'h1234, 16'd1, 16'hFFFF);
        send_word(REQ_ARRIVE, 16'hA5A5, 16'd3, 16'd5);
        send_word(REQ_ARRIVE, 16'h5A5A, 16'd8, 16'd9);
        repeat (5) send_word(REQ_TICK, FIELD_W'($urandom), FIELD_W'($urandom),
                             FIELD_W'($urandom));
        // A zero-length job never completes and leaves only by timeout.
        send_word(REQ_ARRIVE, 16'h00FF, 16'd0, 16'd8);
        repeat (3) send_word(REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(REQ_ARRIVE, 16'h8000, 16'hFFFF, 16'd10);
        repeat (2) send_word(REQ_TICK, 16'h0000, 16'h0000, 16'h0000);
        settle;
        write_qmax(3'd4);
        // Start an already expired job on arrival, then fill the queue and flush five records.
        send_word(REQ_ARRIVE, 16'hC3C3, 16'd1, 16'd0);
        for (int i = 0; i < 4; i++)
            send_word(REQ_ARRIVE, FIELD_W'(16'h0F00 + i), FIELD_W'($urandom), 16'd0);
        send_word(REQ_ARRIVE, 16'h7E7E, 16'd4, 16'hFFFF);
        send_word(REQ_TICK, 16'h0000, 16'h0000, 16'h0000);

        foreach (limits[p]) begin
            settle;
            write_qmax(limits[p]);
            calm = (p == 3);
            repeat (WORDS_PER_PHASE) send_random;
        end

        // A job whose end lies past the clock range, then zero-length and short jobs.
        settle;
        write_qmax(QMAX_RESET);
        calm = 1'b0;
        send_word(REQ_ARRIVE, FIELD_W'($urandom), 16'hFFFF, 16'hFFFF);
        send_word(REQ_ARRIVE, 16'h0D0D, 16'd0, 16'hFFFF);
        send_word(REQ_ARRIVE, 16'h0E0E, 16'd5, 16'hFFFF);
        send_word(REQ_TICK, 16'h0000, 16'h0000, 16'h0000);
        repeat (12) send_random;

        settle;
        @(negedge clk);
        fails = mismatches + awaiting;
        $display("%0d words in, %0d records checked, %0d queue limit writes from 0 to 7",
                 words_in, records_out, cfg_writes);
        $display("covered rejects, flushes of five records, zero-length jobs and output stalls");
        if (fails == 0)
            $display("fifo_job_scheduler_with_timeout_tb passed");
        else
            $display("fifo_job_scheduler_with_timeout_tb failed");
        $finish;
    end

    initial begin : watchdog
        #(8_000_000);
        $display("fifo_job_scheduler_with_timeout_tb failed");
        $finish;
    end

endmodule
